### hw/rtl/sle_pkg.sv
// sle_pkg: shared types, codes and field widths for the sorted list engine.
// No dependencies; imported by sle_ram users and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int CAPACITY_DEF = 16;

  // field widths
  localparam int VAL_W     = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 5;
  localparam int OUT_RAW_W = CNT_W + CNT_W + VAL_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_W - OUT_RAW_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_PLACE,
    ST_RESP,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_list_engine.sv
// sorted_list_engine: bounded sorted list of signed values held in one entry RAM.
// Depends on sle_pkg and sle_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in_     | slave     | in_tvalid / in_tready | tuser: cmd; tdata: value
//  out_    | master    | out_tvalid/out_tready | tuser: status; tdata: match, occ, entry
//  cfg_    | slave     | cfg_valid / cfg_ready | cfg_data: ascending
//
// Steps (n = entries held): clear, full insert and unused codes go straight to
// the response. Count and delete scan all n entries. Insert: scan up to the insert
// point k, backward shift of n - k entries, place. Read out: one word per entry,
// one word a cycle while the output is not stalled, each from a registered RAM read.
// The single read port of the entry RAM sets these steps.
// Reset clears the count and control only; the RAM needs no clearing.
// A stalled output holds its word and the sequencer waits for it.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sle_pkg::VAL_W-1:0]     in_tdata,   // [31:0] value
  input  logic [sle_pkg::CMD_W-1:0]     in_tuser,   // [2:0] cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sle_pkg::OUT_W-1:0]     out_tdata,  // [4:0] match_count, [9:5] occupancy,
                                                    // [41:10] entry_value, rest zero
  output logic [sle_pkg::STATUS_W-1:0]  out_tuser,  // [1:0] status
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data    // ascending
);

  import sle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  function automatic logic [CNT_W-1:0] fit_cnt(input logic [CW-1:0] x);
    logic [CW+CNT_W-1:0] t;
    t = {{CNT_W{1'b0}}, x};
    return t[CNT_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic                 asc_r;
  logic [CW-1:0]        held_r, held_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 found_r, found_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [STATUS_W-1:0]  rsp_status_r, rsp_status_nxt;
  logic [CW-1:0]        rsp_match_r, rsp_match_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_match_r, out_match_nxt;
  logic [CNT_W-1:0]     out_occ_r, out_occ_nxt;
  logic [VAL_W-1:0]     out_entry_r, out_entry_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [VAL_W-1:0]     mem_wdata, mem_rdata;

  logic                 in_fire, out_free, is_end, eq, rank_after, found_c;
  logic [CW-1:0]        idx_inc, idx_dec, held_dec, cnt_c;

  sle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY),
    .ADDR_W(AW)
  ) u_entries (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_entry_r, out_occ_r, out_match_r};

  assign out_free   = !out_valid_r || out_tready;
  assign idx_inc    = idx_r + ONE_C;
  assign idx_dec    = idx_r - ONE_C;
  assign held_dec   = held_r - ONE_C;
  assign is_end     = (idx_inc == held_r);
  assign eq         = (mem_rdata == val_r);
  assign rank_after = asc_r ? ($signed(mem_rdata) > $signed(val_r))
                            : ($signed(mem_rdata) < $signed(val_r));
  assign found_c    = found_r || eq;
  assign cnt_c      = cnt_r + {{(CW-1){1'b0}}, eq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      asc_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        asc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    rsp_status_r <= rsp_status_nxt;
    rsp_match_r  <= rsp_match_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
    out_occ_r    <= out_occ_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    rsp_status_nxt = rsp_status_r;
    rsp_match_nxt  = rsp_match_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_match_nxt  = out_match_r;
    out_occ_nxt    = out_occ_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = val_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_tuser;
          val_nxt        = in_tdata;
          idx_nxt        = '0;
          pos_nxt        = '0;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          rsp_match_nxt  = '0;
          rsp_status_nxt = STS_OK;
          case (in_tuser)
            CMD_INSERT: begin
              if (held_r == CAP_C) begin
                rsp_status_nxt = STS_FULL;
                state_nxt      = ST_RESP;
              end else if (held_r == '0) begin
                state_nxt = ST_PLACE;
              end else begin
                mem_re    = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            CMD_COUNT, CMD_DELETE: begin
              if (held_r == '0) begin
                rsp_status_nxt = STS_NOTFOUND;
                state_nxt      = ST_RESP;
              end else begin
                mem_re    = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              held_nxt  = '0;
              state_nxt = ST_RESP;
            end
            CMD_READ: begin
              if (held_r == '0) begin
                rsp_status_nxt = STS_EMPTY;
                state_nxt      = ST_RESP;
              end else begin
                mem_re    = 1'b1;
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (rank_after) begin
              // insert point found: shift the tail up from the back
              pos_nxt   = idx_r;
              idx_nxt   = held_dec;
              mem_re    = 1'b1;
              mem_raddr = held_dec[AW-1:0];
              state_nxt = ST_SHIFT_UP;
            end else if (is_end) begin
              pos_nxt   = held_r;
              state_nxt = ST_PLACE;
            end else begin
              idx_nxt   = idx_inc;
              mem_re    = 1'b1;
              mem_raddr = idx_inc[AW-1:0];
            end
          end
          CMD_COUNT: begin
            cnt_nxt = cnt_c;
            if (is_end) begin
              rsp_match_nxt  = cnt_c;
              rsp_status_nxt = (cnt_c != '0) ? STS_OK : STS_NOTFOUND;
              state_nxt      = ST_RESP;
            end else begin
              idx_nxt   = idx_inc;
              mem_re    = 1'b1;
              mem_raddr = idx_inc[AW-1:0];
            end
          end
          default: begin
            // delete: once the match is behind, pull each entry down one slot
            if (found_r) begin
              mem_we    = 1'b1;
              mem_waddr = idx_dec[AW-1:0];
              mem_wdata = mem_rdata;
            end
            found_nxt = found_c;
            if (is_end) begin
              if (found_c) begin
                held_nxt       = held_dec;
                rsp_status_nxt = STS_OK;
              end else begin
                rsp_status_nxt = STS_NOTFOUND;
              end
              state_nxt = ST_RESP;
            end else begin
              idx_nxt   = idx_inc;
              mem_re    = 1'b1;
              mem_raddr = idx_inc[AW-1:0];
            end
          end
        endcase
      end

      ST_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc[AW-1:0];
        mem_wdata = mem_rdata;
        if (idx_r == pos_r) begin
          state_nxt = ST_PLACE;
        end else begin
          idx_nxt   = idx_dec;
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end
      end

      ST_PLACE: begin
        mem_we         = 1'b1;
        mem_waddr      = pos_r[AW-1:0];
        mem_wdata      = val_r;
        held_nxt       = held_r + ONE_C;
        rsp_status_nxt = STS_OK;
        state_nxt      = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rsp_status_r;
          out_match_nxt  = fit_cnt(rsp_match_r);
          out_occ_nxt    = fit_cnt(held_r);
          out_entry_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_match_nxt  = '0;
          out_occ_nxt    = fit_cnt(held_r);
          out_entry_nxt  = mem_rdata;
          out_last_nxt   = is_end;
          if (is_end) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            mem_re    = 1'b1;
            mem_raddr = idx_inc[AW-1:0];
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CAP_C)
    else $error("held count above capacity");

  no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("entry RAM written while idle");

  clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_CLEAR) |=> (held_r == '0))
    else $error("clear left entries");

  full_insert_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_INSERT && held_r == CAP_C) |=> (held_r == CAP_C))
    else $error("insert into full list changed count");

endmodule

`default_nettype wire

### hw/rtl/sle_ram.sv
// sle_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### tb/sorted_list_engine_tb.sv
`timescale 1ns / 1ps
// sorted_list_engine_tb: self-checking bench for the sorted list engine.
// Feeds command words, keeps its own copy of the list to predict each result word,
// and compares results in order. Depends on sle_pkg and the sorted_list_engine RTL.

module sorted_list_engine_tb;
  import sle_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
  } cmd_word_t;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic [CNT_W-1:0]        match_count;
    logic [CNT_W-1:0]        occupancy;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [VAL_W-1:0]    in_tdata   = '0;   // [31:0] value
  logic [CMD_W-1:0]    in_tuser   = '0;   // [2:0] cmd
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;         // [4:0] match_count, [9:5] occupancy, [41:10] entry
  logic [STATUS_W-1:0] out_tuser;         // [1:0] status
  logic                out_tlast;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic                cfg_data   = 1'b1;

  // shadow of the list
  logic signed [VAL_W-1:0] list_vals [CAP];
  int                      list_len = 0;
  bit                      order_up = 1'b1;

  cmd_word_t cmd_words[$];
  result_t   pending_results[$];
  int        errors       = 0;
  int        burst_left   = 1;
  int        gap_left     = 0;
  bit        hold_req     = 1'b0;
  int        hold_left    = 0;
  rx_mode_t  rx_mode      = RX_OPEN;
  int        rx_phase     = 0;
  int        quiet_cycles = 0;

  sorted_list_engine #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void push_result(logic [STATUS_W-1:0] st, int hit_num,
                                      logic signed [VAL_W-1:0] entry, logic last);
    result_t r;
    r.status      = st;
    r.match_count = hit_num[CNT_W-1:0];
    r.occupancy   = list_len[CNT_W-1:0];
    r.entry_value = entry;
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  // Update the shadow list for one accepted word and queue its result words.
  function automatic void apply_to_list(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v);
    int pos;
    int hits;
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= CAP) begin
          push_result(STS_FULL, 0, '0, 1'b1);
        end else begin
          // place before the first entry that ranks after v, so ties keep arrival order
          pos = list_len;
          for (int i = 0; i < list_len; i++)
            if (pos == list_len && (order_up ? list_vals[i] > v : list_vals[i] < v))
              pos = i;
          for (int i = list_len; i > pos; i--)
            list_vals[i] = list_vals[i-1];
          list_vals[pos] = v;
          list_len++;
          push_result(STS_OK, 0, '0, 1'b1);
        end
      end
      CMD_COUNT: begin
        hits = 0;
        for (int i = 0; i < list_len; i++)
          if (list_vals[i] == v) hits++;
        push_result(hits != 0 ? STS_OK : STS_NOTFOUND, hits, '0, 1'b1);
      end
      CMD_DELETE: begin
        pos = -1;
        for (int i = 0; i < list_len; i++)
          if (pos < 0 && list_vals[i] == v) pos = i;
        if (pos < 0) begin
          push_result(STS_NOTFOUND, 0, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i+1];
          list_len--;
          push_result(STS_OK, 0, '0, 1'b1);
        end
      end
      CMD_CLEAR: begin
        list_len = 0;
        push_result(STS_OK, 0, '0, 1'b1);
      end
      CMD_READ: begin
        if (list_len == 0)
          push_result(STS_EMPTY, 0, '0, 1'b1);
        else
          for (int i = 0; i < list_len; i++)
            push_result(STS_OK, 0, list_vals[i], i == list_len - 1);
      end
      default: push_result(STS_OK, 0, '0, 1'b1);
    endcase
  endfunction

  // Sender: bursts of words with random gaps between them.
  always @(posedge clk) begin : feed
    cmd_word_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) apply_to_list(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_words.size() != 0) begin
          w = cmd_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= w.cmd;
          in_tdata  <= w.value;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern picked at random for each phase, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        rx_phase = $urandom_range(20, 80);
      end
      rx_phase--;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= (rx_phase % 4 == 0);
        default:   out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $error("unexpected result word: status %0d, tdata %h", out_tuser, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, out_tuser);
        end
        if (out_tdata[CNT_W-1:0] !== want.match_count) begin
          errors++;
          $error("match_count: expected %0d, got %0d", want.match_count,
                 out_tdata[CNT_W-1:0]);
        end
        if (out_tdata[2*CNT_W-1:CNT_W] !== want.occupancy) begin
          errors++;
          $error("occupancy: expected %0d, got %0d", want.occupancy,
                 out_tdata[2*CNT_W-1:CNT_W]);
        end
        if (out_tdata[2*CNT_W+VAL_W-1:2*CNT_W] !== want.entry_value) begin
          errors++;
          $error("entry_value: expected %0d, got %0d", want.entry_value,
                 $signed(out_tdata[2*CNT_W+VAL_W-1:2*CNT_W]));
        end
        if (out_tlast !== want.last) begin
          errors++;
          $error("last: expected %0d, got %0d", want.last, out_tlast);
        end
      end
    end
  end

  // Watchdog: only counts while something is outstanding.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else if (in_tvalid || cfg_valid || pending_results.size() != 0)
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value);
    cmd_word_t w;
    w.cmd   = cmd;
    w.value = value;
    cmd_words.push_back(w);
  endtask

  task automatic wait_idle();
    while (cmd_words.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_order(bit up);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= up;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_up = up;
  endtask

  // Mostly small keys so that matches and ties are common; extremes and full range too.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] near;
    near = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return $urandom;
      default: return near - 3;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_INSERT;
    if (r < 65) return CMD_COUNT;
    if (r < 85) return CMD_DELETE;
    if (r < 95) return CMD_READ;
    if (r < 97) return CMD_CLEAR;
    case ($urandom_range(0, 2))
      0:       return CMD_SPARE_5;
      1:       return CMD_SPARE_6;
      default: return CMD_SPARE_7;
    endcase
  endfunction

  task automatic test_directed();
    send_word(CMD_READ, '0);          // empty list read out
    send_word(CMD_DELETE, 32'd5);     // delete on empty list
    send_word(CMD_COUNT, '0);
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_INSERT, '0);
    send_word(CMD_INSERT, '0);        // tie goes after the first zero
    send_word(CMD_INSERT, '1);
    send_word(CMD_COUNT, '0);
    send_word(CMD_COUNT, 32'd9);      // no match
    send_word(CMD_DELETE, '0);
    send_word(CMD_DELETE, 32'd42);    // delete with no match
    send_word(CMD_READ, '0);
    send_word(CMD_SPARE_5, $urandom);
    send_word(CMD_SPARE_6, $urandom);
    send_word(CMD_SPARE_7, $urandom);
    send_word(CMD_CLEAR, '0);
    send_word(CMD_READ, '0);
    wait_idle();
  endtask

  task automatic test_descending();
    write_order(1'b0);
    send_word(CMD_INSERT, 32'd3);
    send_word(CMD_INSERT, -32'sd2);
    send_word(CMD_INSERT, 32'd3);
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_READ, '0);
    // flip order with entries held: nothing is re-sorted
    write_order(1'b1);
    send_word(CMD_INSERT, 32'd1);
    send_word(CMD_READ, '0);
    send_word(CMD_CLEAR, '0);
    wait_idle();
  endtask

  task automatic test_fill();
    write_order($urandom_range(0, 1));
    repeat (CAP) send_word(CMD_INSERT, pick_value());
    send_word(CMD_INSERT, pick_value());   // full
    send_word(CMD_INSERT, VAL_MIN);        // still full
    send_word(CMD_READ, '0);
    send_word(CMD_COUNT, pick_value());
    send_word(CMD_DELETE, pick_value());
    send_word(CMD_INSERT, pick_value());
    send_word(CMD_READ, '0);
    send_word(CMD_CLEAR, '0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    repeat (40) send_word(pick_cmd(), pick_value());
    wait_idle();
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 240; n++) begin
      if (n % 60 == 59) write_order($urandom_range(0, 1));
      send_word(pick_cmd(), pick_value());
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_descending();
    test_fill();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
